// ===== hdl/hsp_pkg.sv =====
package hsp_pkg;

  // tile edge in pixels
  localparam int TILE_SIZE_DEF = 16;

  // input opcodes
  localparam logic OP_HEADER = 1'b0;
  localparam logic OP_BYTE   = 1'b1;

  // pixel size register codes
  localparam logic [1:0] PIX_ONE_BYTE  = 2'd0;
  localparam logic [1:0] PIX_TWO_BYTES = 2'd1;

  // subencoding bit positions
  localparam int SE_RAW_BIT      = 0;
  localparam int SE_BG_BIT       = 1;
  localparam int SE_FG_BIT       = 2;
  localparam int SE_ANY_BIT      = 3;
  localparam int SE_COLOURED_BIT = 4;

  typedef enum logic [3:0] {
    ROLE_SUBENC     = 4'd0,
    ROLE_RAW        = 4'd1,
    ROLE_BG         = 4'd2,
    ROLE_FG         = 4'd3,
    ROLE_COUNT      = 4'd4,
    ROLE_SUBCOLOUR  = 4'd5,
    ROLE_SUBPOS     = 4'd6,
    ROLE_SUBSIZE    = 4'd7,
    ROLE_UNEXPECTED = 4'd8
  } role_t;

  typedef struct packed {
    logic        opcode;
    logic [15:0] rect_x;
    logic [15:0] rect_y;
    logic [15:0] rect_width;
    logic [15:0] rect_height;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic [3:0]  byte_role;
    logic [15:0] tile_x;
    logic [15:0] tile_y;
    logic [4:0]  tile_width;
    logic [4:0]  tile_height;
    logic        tile_done;
    logic        rect_done;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t data;
  } push_t;

endpackage

// ===== hdl/hsp_if.sv =====
interface hsp_stream_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] rect_x;
  logic [15:0] rect_y;
  logic [15:0] rect_width;
  logic [15:0] rect_height;
  logic [7:0]  data_byte;

  modport source (
    output valid, opcode, rect_x, rect_y, rect_width, rect_height, data_byte,
    input  ready
  );
  modport sink (
    input  valid, opcode, rect_x, rect_y, rect_width, rect_height, data_byte,
    output ready
  );
endinterface

interface hsp_label_if;
  logic        valid;
  logic        ready;
  logic [3:0]  byte_role;
  logic [15:0] tile_x;
  logic [15:0] tile_y;
  logic [4:0]  tile_width;
  logic [4:0]  tile_height;
  logic        tile_done;
  logic        rect_done;

  modport source (
    output valid, byte_role, tile_x, tile_y, tile_width, tile_height, tile_done,
           rect_done,
    input  ready
  );
  modport sink (
    input  valid, byte_role, tile_x, tile_y, tile_width, tile_height, tile_done,
           rect_done,
    output ready
  );
endinterface

// ===== hdl/hsp_parser_core.sv =====
module hsp_parser_core import hsp_pkg::*; #(
  parameter int TILE_SIZE = TILE_SIZE_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  input  logic       accept,
  input  item_t      item,
  output push_t      push
);

  localparam int CW = $clog2(TILE_SIZE + 1);
  localparam int BW = $clog2(TILE_SIZE * TILE_SIZE * 4 + 1);
  localparam int PW = 2 * CW;
  localparam logic [16:0] STEP = 17'(TILE_SIZE);

  localparam logic [1:0] STAGE_BG    = 2'd0;
  localparam logic [1:0] STAGE_FG    = 2'd1;
  localparam logic [1:0] STAGE_COUNT = 2'd2;

  typedef enum logic [6:0] {
    PH_IDLE   = 7'b0000001,
    PH_SUBENC = 7'b0000010,
    PH_RAW    = 7'b0000100,
    PH_BG     = 7'b0001000,
    PH_FG     = 7'b0010000,
    PH_COUNT  = 7'b0100000,
    PH_SUBR   = 7'b1000000
  } phase_t;

  // clipped tile extent, offset known to be below size
  function automatic logic [CW-1:0] clip(input logic [15:0] size, input logic [15:0] off);
    logic [15:0] rest;
    rest = size - off;
    if (rest < 16'(TILE_SIZE)) begin
      clip = CW'(rest);
    end else begin
      clip = CW'(TILE_SIZE);
    end
  endfunction

  phase_t          phase, phase_next;
  logic [1:0]      pix_code;
  logic [15:0]     origin_x, origin_x_next;
  logic [15:0]     size_w, size_w_next;
  logic [15:0]     size_h, size_h_next;
  logic [15:0]     off_x, off_x_next;
  logic [15:0]     off_y, off_y_next;
  logic [15:0]     tile_x, tile_x_next;
  logic [15:0]     tile_y, tile_y_next;
  logic [CW-1:0]   tile_w, tile_w_next;
  logic [CW-1:0]   tile_h, tile_h_next;
  logic [4:0]      flags, flags_next;
  logic [BW-1:0]   bytes_left, bytes_left_next;
  logic [7:0]      subrects_left, subrects_left_next;
  logic [2:0]      sub_idx, sub_idx_next;

  logic [1:0]      pb_shift;
  logic [BW-1:0]   pix_len;
  logic [PW-1:0]   raw_prod;
  logic [BW-1:0]   raw_len;
  logic [2:0]      colour_len;
  logic [BW-1:0]   bytes_dec;
  logic [16:0]     sum_x, sum_y;
  logic            x_wrap, y_wrap;
  logic [4:0]      part_flags;
  logic            part_req;
  logic [1:0]      part_stage;
  logic            tdone, rdone;
  result_t         res;
  logic            res_valid;

  always_comb begin
    unique case (pix_code)
      PIX_ONE_BYTE:  pb_shift = 2'd0;
      PIX_TWO_BYTES: pb_shift = 2'd1;
      default:       pb_shift = 2'd2;
    endcase
  end

  assign pix_len    = BW'(1) << pb_shift;
  assign raw_prod   = PW'(tile_w) * PW'(tile_h);
  assign raw_len    = BW'(raw_prod) << pb_shift;
  assign colour_len = flags[SE_COLOURED_BIT] ? 3'(3'd1 << pb_shift) : 3'd0;
  assign bytes_dec  = bytes_left - BW'(bytes_left != '0);
  assign sum_x      = {1'b0, off_x} + STEP;
  assign sum_y      = {1'b0, off_y} + STEP;
  assign x_wrap     = sum_x >= {1'b0, size_w};
  assign y_wrap     = sum_y >= {1'b0, size_h};
  assign part_flags = (phase == PH_SUBENC) ? item.data_byte[4:0] : flags;

  always_comb begin
    phase_next         = phase;
    origin_x_next      = origin_x;
    size_w_next        = size_w;
    size_h_next        = size_h;
    off_x_next         = off_x;
    off_y_next         = off_y;
    tile_x_next        = tile_x;
    tile_y_next        = tile_y;
    tile_w_next        = tile_w;
    tile_h_next        = tile_h;
    flags_next         = flags;
    bytes_left_next    = bytes_left;
    subrects_left_next = subrects_left;
    sub_idx_next       = sub_idx;
    part_req           = 1'b0;
    part_stage         = STAGE_BG;
    tdone              = 1'b0;
    rdone              = 1'b0;
    res                = '0;
    res_valid          = 1'b0;

    if (accept && item.opcode == OP_HEADER) begin
      origin_x_next      = item.rect_x;
      tile_x_next        = item.rect_x;
      tile_y_next        = item.rect_y;
      size_w_next        = item.rect_width;
      size_h_next        = item.rect_height;
      off_x_next         = '0;
      off_y_next         = '0;
      tile_w_next        = clip(item.rect_width, 16'd0);
      tile_h_next        = clip(item.rect_height, 16'd0);
      flags_next         = '0;
      bytes_left_next    = '0;
      subrects_left_next = '0;
      sub_idx_next       = '0;
      if (item.rect_width == '0 || item.rect_height == '0) begin
        phase_next = PH_IDLE;
      end else begin
        phase_next = PH_SUBENC;
      end
    end else if (accept) begin
      res_valid       = 1'b1;
      res.tile_x      = tile_x;
      res.tile_y      = tile_y;
      res.tile_width  = 5'(tile_w);
      res.tile_height = 5'(tile_h);
      unique case (phase)
        PH_IDLE: begin
          res = '0;
          res.byte_role = ROLE_UNEXPECTED;
        end
        PH_SUBENC: begin
          res.byte_role = ROLE_SUBENC;
          flags_next    = item.data_byte[4:0];
          if (item.data_byte[SE_RAW_BIT]) begin
            phase_next      = PH_RAW;
            bytes_left_next = raw_len;
          end else begin
            part_req   = 1'b1;
            part_stage = STAGE_BG;
          end
        end
        PH_RAW: begin
          res.byte_role   = ROLE_RAW;
          bytes_left_next = bytes_dec;
          tdone           = (bytes_dec == '0);
        end
        PH_BG, PH_FG: begin
          res.byte_role   = (phase == PH_BG) ? ROLE_BG : ROLE_FG;
          bytes_left_next = bytes_dec;
          if (bytes_dec == '0) begin
            part_req   = 1'b1;
            part_stage = (phase == PH_BG) ? STAGE_FG : STAGE_COUNT;
          end
        end
        PH_COUNT: begin
          res.byte_role      = ROLE_COUNT;
          subrects_left_next = item.data_byte;
          sub_idx_next       = '0;
          if (item.data_byte == '0) begin
            tdone = 1'b1;
          end else begin
            phase_next = PH_SUBR;
          end
        end
        PH_SUBR: begin
          if (sub_idx < colour_len) begin
            res.byte_role = ROLE_SUBCOLOUR;
            sub_idx_next  = sub_idx + 3'd1;
          end else if (sub_idx == colour_len) begin
            res.byte_role = ROLE_SUBPOS;
            sub_idx_next  = sub_idx + 3'd1;
          end else begin
            res.byte_role      = ROLE_SUBSIZE;
            sub_idx_next       = '0;
            subrects_left_next = subrects_left - 8'(subrects_left != '0);
            tdone              = (subrects_left_next == '0);
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase

      // next part of a tile that is not raw
      if (part_req) begin
        if (part_stage == STAGE_BG && part_flags[SE_BG_BIT]) begin
          phase_next      = PH_BG;
          bytes_left_next = pix_len;
        end else if (part_stage != STAGE_COUNT && part_flags[SE_FG_BIT]) begin
          phase_next      = PH_FG;
          bytes_left_next = pix_len;
        end else if (part_flags[SE_ANY_BIT]) begin
          phase_next = PH_COUNT;
        end else begin
          tdone = 1'b1;
        end
      end

      // step to the next tile, left to right then top to bottom
      if (tdone) begin
        phase_next = PH_SUBENC;
        if (!x_wrap) begin
          off_x_next  = sum_x[15:0];
          tile_x_next = tile_x + 16'(TILE_SIZE);
          tile_w_next = clip(size_w, sum_x[15:0]);
        end else begin
          off_x_next  = '0;
          tile_x_next = origin_x;
          tile_w_next = clip(size_w, 16'd0);
          if (!y_wrap) begin
            off_y_next  = sum_y[15:0];
            tile_y_next = tile_y + 16'(TILE_SIZE);
            tile_h_next = clip(size_h, sum_y[15:0]);
          end else begin
            off_y_next = '0;
            phase_next = PH_IDLE;
            rdone      = 1'b1;
          end
        end
      end
      res.tile_done = tdone;
      res.rect_done = rdone;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      pix_code <= PIX_ONE_BYTE;
    end else begin
      phase <= phase_next;
      if (cfg_wr_en) begin
        pix_code <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    origin_x      <= origin_x_next;
    size_w        <= size_w_next;
    size_h        <= size_h_next;
    off_x         <= off_x_next;
    off_y         <= off_y_next;
    tile_x        <= tile_x_next;
    tile_y        <= tile_y_next;
    tile_w        <= tile_w_next;
    tile_h        <= tile_h_next;
    flags         <= flags_next;
    bytes_left    <= bytes_left_next;
    subrects_left <= subrects_left_next;
    sub_idx       <= sub_idx_next;
  end

  assign push.valid = res_valid;
  assign push.data  = res;

endmodule

// ===== hdl/hsp_out_fifo.sv =====
module hsp_out_fifo import hsp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  output logic  full,
  hsp_label_if.source label
);

  localparam int DEPTH = 2;

  result_t    slot [DEPTH];
  result_t    head;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop  = label.valid && label.ready;
  assign full = (count == 2'(DEPTH));
  assign head = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push.valid) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slot[wr_ptr] <= push.data;
    end
  end

  assign label.valid       = (count != '0);
  assign label.byte_role   = head.byte_role;
  assign label.tile_x      = head.tile_x;
  assign label.tile_y      = head.tile_y;
  assign label.tile_width  = head.tile_width;
  assign label.tile_height = head.tile_height;
  assign label.tile_done   = head.tile_done;
  assign label.rect_done   = head.rect_done;

endmodule

// ===== hdl/hextile_stream_parser.sv =====
// channel  | role   | word
// ---------+--------+-------------------------------------------------------
// stream   | sink   | opcode, rect_x/y, rect_width/height, data_byte
// label    | source | byte_role, tile_x/y, tile_width/height, tile_done, rect_done
// cfg      | write  | cfg_wr_en, cfg_wr_data (pixel size code)
//
// one stream word per cycle while the label queue has room; a byte word is
// labelled in the cycle it is taken and shown on the label channel once it
// heads the queue. the label side is a two-word queue, so a stalled label still
// lets one more word in; stream.ready drops only when both slots are held
// rst is synchronous and active high: block idle, queue empty, pixel size one byte
// headers give no label; they restart the tile walk at the top-left tile
module hextile_stream_parser import hsp_pkg::*; #(
  parameter int TILE_SIZE = TILE_SIZE_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  hsp_stream_if.sink   stream,
  hsp_label_if.source  label
);

  item_t item;
  push_t push;
  logic  full;
  logic  accept;

  // take a word whenever the label queue has a free slot
  assign stream.ready = !full;
  assign accept       = stream.valid && stream.ready;

  // pack the stream word for the parser
  assign item.opcode      = stream.opcode;
  assign item.rect_x      = stream.rect_x;
  assign item.rect_y      = stream.rect_y;
  assign item.rect_width  = stream.rect_width;
  assign item.rect_height = stream.rect_height;
  assign item.data_byte   = stream.data_byte;

  // tile walker and byte labelling, one word per cycle while the queue has room
  hsp_parser_core #(
    .TILE_SIZE (TILE_SIZE)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .item        (item),
    .push        (push)
  );

  // result register plus skid slot
  hsp_out_fifo u_out (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .label (label)
  );

endmodule

// ===== hdl/hsp_checker.sv =====
module hsp_checker import hsp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        label_valid,
  input logic        label_ready,
  input logic [3:0]  byte_role,
  input logic [15:0] tile_x,
  input logic [15:0] tile_y,
  input logic [4:0]  tile_width,
  input logic [4:0]  tile_height,
  input logic        tile_done,
  input logic        rect_done
);

  // stalled label word holds
  a_label_hold: assert property (@(posedge clk) disable iff (rst)
    label_valid && !label_ready |=> label_valid && $stable(byte_role) &&
      $stable(tile_x) && $stable(tile_y) && $stable(tile_done) && $stable(rect_done))
    else $error("label word changed while stalled");

  // end of rectangle is always the end of a tile
  a_rect_in_tile: assert property (@(posedge clk) disable iff (rst)
    label_valid && rect_done |-> tile_done)
    else $error("rect_done without tile_done");

  // unexpected byte carries no tile
  a_unexpected_clear: assert property (@(posedge clk) disable iff (rst)
    label_valid && byte_role == ROLE_UNEXPECTED |->
      tile_x == '0 && tile_y == '0 && tile_width == '0 && tile_height == '0 &&
      !tile_done && !rect_done)
    else $error("unexpected byte with tile fields set");

  // colour and position bytes never close a subrect
  a_mid_subrect: assert property (@(posedge clk) disable iff (rst)
    label_valid && (byte_role == ROLE_SUBCOLOUR || byte_role == ROLE_SUBPOS) |->
      !tile_done)
    else $error("tile closed inside a subrect");

endmodule

bind hextile_stream_parser hsp_checker u_hsp_checker (
  .clk         (clk),
  .rst         (rst),
  .label_valid (label.valid),
  .label_ready (label.ready),
  .byte_role   (label.byte_role),
  .tile_x      (label.tile_x),
  .tile_y      (label.tile_y),
  .tile_width  (label.tile_width),
  .tile_height (label.tile_height),
  .tile_done   (label.tile_done),
  .rect_done   (label.rect_done)
);
